// ===== rtl/cursor_list_free_list_insert_defines.svh =====
// assertion macros for the cursor list insert block
// expects clk and rst in the scope of each use
`ifndef CURSOR_LIST_FREE_LIST_INSERT_DEFINES_SVH
`define CURSOR_LIST_FREE_LIST_INSERT_DEFINES_SVH

// condition implies consequence in the same cycle
`define CLFFL_ASSERT_NOW(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("cursor list insert: check failed");

// condition implies consequence in the following cycle
`define CLFFL_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("cursor list insert: check failed");

`endif

// ===== rtl/clffl_pkg.sv =====
// types and constants for the cursor list insert block
// no dependencies
package clffl_pkg;

  localparam int IDX_W = 4;
  localparam int VAL_W = 8;

  localparam logic [IDX_W-1:0] NIL_IDX = 4'hF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_TAKE,
    ST_WALK
  } state_t;

endpackage

// ===== rtl/clffl_link_mem.sv =====
// link store: one write port, one registered read port, per-entry valid bits
// an entry never written reads as its reset link; a same-cycle write is forwarded
module clffl_link_mem #(
  parameter int NODES = 8
) (
  clk,
  rst,
  re,
  raddr,
  we,
  waddr,
  wdata,
  rdata
);

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW = AW + 1;

  input  logic          clk;
  input  logic          rst;
  input  logic          re;
  input  logic [AW-1:0] raddr;
  input  logic          we;
  input  logic [AW-1:0] waddr;
  input  logic [LW-1:0] wdata;
  output logic [LW-1:0] rdata;

  logic [LW-1:0] mem [NODES];
  logic [NODES-1:0] valid;
  logic [LW-1:0] rd_q;
  logic          vld_q;
  logic [AW-1:0] ra_q;
  logic          fwd_q;
  logic [LW-1:0] fwd_data;
  logic [LW-1:0] rst_link;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q     <= mem[raddr];
      vld_q    <= valid[raddr];
      ra_q     <= raddr;
      fwd_q    <= we && (waddr == raddr);
      fwd_data <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // chain 0,1,...,NODES-1 then end of list
  always_comb begin
    if (ra_q == AW'(NODES - 1)) begin
      rst_link = {1'b1, {AW{1'b0}}};
    end else begin
      rst_link = {1'b0, ra_q + AW'(1)};
    end
  end

  assign rdata = fwd_q ? fwd_data : (vld_q ? rd_q : rst_link);

endmodule

// ===== rtl/cursor_list_free_list_insert.sv =====
// top level of the cursor list insert block: control, free list head, byte store
// depends on clffl_pkg, clffl_link_mem and cursor_list_free_list_insert_defines.svh
//
// usage:
//   a transaction is taken when start is high and busy is low; it carries
//   action (0 insert first, 1 insert last), head (-1 for an empty list) and value
//   one result per transaction: done pulses for one cycle with new_head,
//   node_used (-1 when the store is full) and full_res
//   states from the accepting edge to the done cycle:
//     store full: ALLOC alone
//     insert first, or insert last into an empty list: ALLOC, then TAKE
//     insert last otherwise: ALLOC, TAKE, then WALK over k links, k from 1 to NODES
//   the walk reads one link per cycle through the single read port of the link store
//   busy falls in the done cycle, so the next transaction can be taken there
//   the receiver cannot stall: results are never held
//   reset: synchronous; the free list is the chain 0,1,...,NODES-1 with head 0,
//   held by valid bits in the link store, so no clearing pass is needed
//
module cursor_list_free_list_insert #(
  parameter int NODES = 8
) (
  clk,
  rst,
  start,
  busy,
  action,
  head,
  value,
  done,
  new_head,
  node_used,
  full_res
);

  import clffl_pkg::*;
  `include "cursor_list_free_list_insert_defines.svh"

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW = AW + 1;

  input  logic                                clk;
  input  logic                                rst;
  input  logic                                start;
  output logic                                busy;
  input  logic                                action;
  input  logic signed [clffl_pkg::IDX_W-1:0]  head;
  input  logic        [clffl_pkg::VAL_W-1:0]  value;
  output logic                                done;
  output logic signed [clffl_pkg::IDX_W-1:0]  new_head;
  output logic signed [clffl_pkg::IDX_W-1:0]  node_used;
  output logic                                full_res;

  state_t state, state_next;

  logic             act, act_next;
  logic             head_nil, head_nil_next;
  logic [AW-1:0]    head_idx, head_idx_next;
  logic [VAL_W-1:0] val, val_next;
  logic [AW-1:0]    alloc, alloc_next;
  logic [AW-1:0]    cur, cur_next;
  logic [AW-1:0]    steps, steps_next;
  logic             free_nil, free_nil_next;
  logic [AW-1:0]    free_idx, free_idx_next;
  logic             done_next;
  logic [IDX_W-1:0] new_head_next;
  logic [IDX_W-1:0] node_used_next;
  logic             full_res_next;

  logic             ln_re;
  logic [AW-1:0]    ln_raddr;
  logic             ln_we;
  logic [AW-1:0]    ln_waddr;
  logic [LW-1:0]    ln_wdata;
  logic [LW-1:0]    ln_rdata;
  logic             val_we;
  logic             head_ok;

  logic [VAL_W-1:0] node_value [NODES];

  clffl_link_mem #(
    .NODES(NODES)
  ) u_link (
    .clk  (clk),
    .rst  (rst),
    .re   (ln_re),
    .raddr(ln_raddr),
    .we   (ln_we),
    .waddr(ln_waddr),
    .wdata(ln_wdata),
    .rdata(ln_rdata)
  );

  always_ff @(posedge clk) begin
    if (val_we) begin
      node_value[alloc] <= val;
    end
  end

  assign head_ok = !head[IDX_W-1] && (32'(head[IDX_W-2:0]) < 32'(NODES));
  assign busy    = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      free_nil <= 1'b0;
      free_idx <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      free_nil <= free_nil_next;
      free_idx <= free_idx_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    act       <= act_next;
    head_nil  <= head_nil_next;
    head_idx  <= head_idx_next;
    val       <= val_next;
    alloc     <= alloc_next;
    cur       <= cur_next;
    steps     <= steps_next;
    new_head  <= new_head_next;
    node_used <= node_used_next;
    full_res  <= full_res_next;
  end

  always_comb begin
    state_next     = state;
    act_next       = act;
    head_nil_next  = head_nil;
    head_idx_next  = head_idx;
    val_next       = val;
    alloc_next     = alloc;
    cur_next       = cur;
    steps_next     = steps;
    free_nil_next  = free_nil;
    free_idx_next  = free_idx;
    done_next      = 1'b0;
    new_head_next  = new_head;
    node_used_next = node_used;
    full_res_next  = full_res;
    ln_re          = 1'b0;
    ln_raddr       = free_idx;
    ln_we          = 1'b0;
    ln_waddr       = alloc;
    ln_wdata       = '0;
    val_we         = 1'b0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          act_next      = action;
          head_nil_next = !head_ok;
          head_idx_next = AW'(head[IDX_W-2:0]);
          val_next      = value;
          state_next    = ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        if (free_nil) begin
          done_next      = 1'b1;
          full_res_next  = 1'b1;
          new_head_next  = head_nil ? NIL_IDX : IDX_W'(head_idx);
          node_used_next = NIL_IDX;
          state_next     = ST_IDLE;
        end else begin
          ln_re      = 1'b1;
          ln_raddr   = free_idx;
          alloc_next = free_idx;
          state_next = ST_TAKE;
        end
      end
      ST_TAKE: begin
        free_nil_next  = ln_rdata[AW];
        free_idx_next  = ln_rdata[AW-1:0];
        val_we         = 1'b1;
        ln_we          = 1'b1;
        ln_waddr       = alloc;
        full_res_next  = 1'b0;
        node_used_next = IDX_W'(alloc);
        if (!act) begin
          ln_wdata      = {head_nil, head_idx};
          done_next     = 1'b1;
          new_head_next = IDX_W'(alloc);
          state_next    = ST_IDLE;
        end else begin
          ln_wdata = {1'b1, {AW{1'b0}}};
          if (head_nil) begin
            done_next     = 1'b1;
            new_head_next = IDX_W'(alloc);
            state_next    = ST_IDLE;
          end else begin
            ln_re      = 1'b1;
            ln_raddr   = head_idx;
            cur_next   = head_idx;
            steps_next = '0;
            state_next = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (ln_rdata[AW] || (steps == AW'(NODES - 1))) begin
          // tail found, or link budget spent: attach the new node
          ln_we         = 1'b1;
          ln_waddr      = ln_rdata[AW] ? cur : ln_rdata[AW-1:0];
          ln_wdata      = {1'b0, alloc};
          done_next     = 1'b1;
          new_head_next = IDX_W'(head_idx);
          state_next    = ST_IDLE;
        end else begin
          cur_next   = ln_rdata[AW-1:0];
          steps_next = steps + AW'(1);
          ln_re      = 1'b1;
          ln_raddr   = ln_rdata[AW-1:0];
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `CLFFL_ASSERT_NOW(a_full_no_node, done && full_res, node_used == NIL_IDX)
  `CLFFL_ASSERT_NEXT(a_full_reports, (state == ST_ALLOC) && free_nil, done && full_res)
  `CLFFL_ASSERT_NEXT(a_done_single, done, !done)

endmodule

// ===== dv/list_insert_checker.sv =====
`timescale 1ns / 100ps
// result checker for the cursor list insert block: predicts each transaction from its inputs
// and compares the strobed results in order; depends on clffl_pkg only
module list_insert_checker #(
  parameter int NODES = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         action,
  input  logic [clffl_pkg::IDX_W-1:0]  head,
  input  logic [clffl_pkg::VAL_W-1:0]  value,
  input  logic                         done,
  input  logic [clffl_pkg::IDX_W-1:0]  new_head,
  input  logic [clffl_pkg::IDX_W-1:0]  node_used,
  input  logic                         full_res,
  output int                           fail_count,
  output int                           pending
);
  import clffl_pkg::*;

  localparam bit ACT_FIRST = 1'b0;
  localparam int NO_NODE = -1;

  typedef struct packed {
    logic [IDX_W-1:0] new_head;
    logic [IDX_W-1:0] node_used;
    logic             full_res;
  } insert_result_t;

  int link_next [NODES];
  int avail;
  int errors;
  insert_result_t awaited_results [$];

  assign fail_count = errors;
  assign pending = awaited_results.size();

  function automatic insert_result_t predict_insert(logic act, logic [IDX_W-1:0] hraw);
    int hd;
    int n;
    int cur;
    int nx;
    bit at_tail;
    insert_result_t r;
    hd = $signed(hraw);
    if (hd < 0 || hd >= NODES) hd = NO_NODE;
    r.full_res = 1'b0;
    r.new_head = hd[IDX_W-1:0];
    n = avail;
    if (n >= 0 && n < NODES) begin
      avail = link_next[n];
    end else begin
      avail = NO_NODE;
      n = NO_NODE;
    end
    if (n == NO_NODE) begin
      r.full_res = 1'b1;
    end else if (act == ACT_FIRST) begin
      link_next[n] = hd;
      r.new_head = n[IDX_W-1:0];
    end else begin
      link_next[n] = NO_NODE;
      if (hd == NO_NODE) begin
        r.new_head = n[IDX_W-1:0];
      end else begin
        // walk at most NODES links, a cycle ends at the node reached last
        cur = hd;
        at_tail = 1'b0;
        for (int s = 0; s < NODES && !at_tail; s++) begin
          nx = link_next[cur];
          if (nx < 0 || nx >= NODES) at_tail = 1'b1;
          else cur = nx;
        end
        link_next[cur] = n;
      end
    end
    r.node_used = n[IDX_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    insert_result_t exp_r;
    if (rst) begin
      for (int i = 0; i < NODES; i++) link_next[i] = (i + 1 < NODES) ? i + 1 : NO_NODE;
      avail = 0;
      awaited_results.delete();
    end else begin
      if (done === 1'b1) begin
        if (awaited_results.size() == 0) begin
          $error("result strobed with no transaction outstanding");
          errors++;
        end else begin
          exp_r = awaited_results.pop_front();
          if (new_head !== exp_r.new_head) begin
            $error("new_head mismatch: expected %0d, actual %0d",
                   $signed(exp_r.new_head), $signed(new_head));
            errors++;
          end
          if (node_used !== exp_r.node_used) begin
            $error("node_used mismatch: expected %0d, actual %0d",
                   $signed(exp_r.node_used), $signed(node_used));
            errors++;
          end
          if (full_res !== exp_r.full_res) begin
            $error("full_res mismatch: expected %0d, actual %0d", exp_r.full_res, full_res);
            errors++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) awaited_results.push_back(predict_insert(action, head));
    end
  end

  initial errors = 0;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// top of the cursor list insert testbench: clock, reset, stimulus and verdict
// depends on clffl_pkg, cursor_list_free_list_insert and list_insert_checker
module testbench;
  import clffl_pkg::*;

  localparam int NODES = 8;
  localparam int IDLE_LIMIT = 400;
  localparam bit ACT_FIRST = 1'b0;
  localparam bit ACT_LAST = 1'b1;
  localparam int DIRECTED = 18;
  localparam int RANDOM_ITEMS = 1900;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic             action;
  logic [IDX_W-1:0] head;
  logic [VAL_W-1:0] value;
  logic             done;
  logic [IDX_W-1:0] new_head;
  logic [IDX_W-1:0] node_used;
  logic             full_res;
  int               fail_count;
  int               pending;
  int               idle_cycles;

  // front/back, head, byte: fills the store, self-loop, cyclic walk, bad heads, free heads
  bit         dir_act [DIRECTED] = '{ACT_FIRST, ACT_LAST, ACT_LAST, ACT_LAST, ACT_FIRST,
                                     ACT_LAST, ACT_LAST, ACT_FIRST, ACT_LAST, ACT_FIRST,
                                     ACT_LAST, ACT_FIRST, ACT_LAST, ACT_FIRST, ACT_LAST,
                                     ACT_FIRST, ACT_LAST, ACT_FIRST};
  logic [3:0] dir_head [DIRECTED] = '{4'hF, 4'h0, 4'h2, 4'h2, 4'h8, 4'h7, 4'hD, 4'h0, 4'h3,
                                     4'h5, 4'hF, 4'h1, 4'h6, 4'hE, 4'h4, 4'h7, 4'h8, 4'h9};
  logic [7:0] dir_val [DIRECTED] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'h7F, 8'hFE,
                                     8'h3C, 8'hC3, 8'h00, 8'hFF, 8'h11, 8'hEE, 8'h22, 8'hDD,
                                     8'h00, 8'hFF};

  cursor_list_free_list_insert #(.NODES(NODES)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .head(head), .value(value),
    .done(done), .new_head(new_head), .node_used(node_used), .full_res(full_res)
  );

  list_insert_checker #(.NODES(NODES)) u_insert_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .head(head), .value(value),
    .done(done), .new_head(new_head), .node_used(node_used), .full_res(full_res),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic issue_insert(bit act, logic [3:0] hd, logic [7:0] val, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    head <= hd;
    value <= val;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL cursor_list_free_list_insert");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit gaps_on;
    int gap;
    logic [3:0] hd;
    start <= 1'b0;
    action <= ACT_FIRST;
    head <= '1;
    value <= '0;
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED; i++) begin
      issue_insert(dir_act[i], dir_head[i], dir_val[i], $urandom_range(11, 0) * (i % 2));
    end

    // hold off until the store of outstanding results is empty
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    gaps_on = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) gaps_on = ($urandom_range(2, 0) != 0);
      gap = gaps_on ? $urandom_range(11, 0) : 0;
      if ($urandom_range(3, 0) != 0) hd = 4'($urandom_range(NODES - 1, 0));
      else hd = 4'($urandom_range(15, 0));
      issue_insert(1'($urandom_range(1, 0)), hd, 8'($urandom_range(255, 0)), gap);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (3 + NODES + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS cursor_list_free_list_insert");
    end else begin
      $display("FAIL cursor_list_free_list_insert");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/clffl_pkg.sv
rtl/clffl_link_mem.sv
rtl/cursor_list_free_list_insert.sv
dv/list_insert_checker.sv
dv/testbench.sv
